// ===== sv/assert_macros.svh =====
// Assertion macros shared by the intersection block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds whenever the antecedent holds
`define RTI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an expression never holds
`define RTI_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== sv/rti_pkg.sv =====
// Shared types, constants and the divide step of the intersection block
`default_nettype none

package rti_pkg;

    localparam int COORD_BITS   = 20;
    localparam int EDGE_BITS    = COORD_BITS + 1;
    localparam int PV_BITS      = COORD_BITS + EDGE_BITS + 1;
    localparam int NRM_BITS     = 2 * EDGE_BITS + 1;
    localparam int PROD_BITS    = EDGE_BITS + NRM_BITS;
    localparam int SUM_BITS     = PROD_BITS + 2;
    localparam int MAG_BITS     = SUM_BITS - 1;
    localparam int VERTEX_BITS  = 3 * COORD_BITS;
    localparam int MIN_BITS     = 32;
    localparam int DIST_BITS    = 32;
    localparam int DIST_FRAC    = 16;
    localparam int WEIGHT_BITS  = DIST_FRAC + 1;
    localparam int FRONT_STAGES = 7;
    localparam int LATENCY      = FRONT_STAGES + DIST_BITS + 1;
    localparam int INDEX_BITS   = 2;

    localparam logic [INDEX_BITS-1:0] REG_VERTEX_A = INDEX_BITS'(0);
    localparam logic [INDEX_BITS-1:0] REG_VERTEX_B = INDEX_BITS'(1);
    localparam logic [INDEX_BITS-1:0] REG_VERTEX_C = INDEX_BITS'(2);
    localparam logic [INDEX_BITS-1:0] REG_MIN_DIST = INDEX_BITS'(3);

    localparam logic [MIN_BITS-1:0]    MIN_DIST_RESET = MIN_BITS'(66);
    localparam logic [DIST_BITS-1:0]   DIST_MISS      = '1;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE     = WEIGHT_BITS'(1) << DIST_FRAC;

    localparam int NEXT1 [3] = '{1, 2, 0};
    localparam int NEXT2 [3] = '{2, 0, 1};

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [EDGE_BITS-1:0]  edge_t;
    typedef logic signed [PV_BITS-1:0]    pv_t;
    typedef logic signed [NRM_BITS-1:0]   nrm_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;
    typedef logic [MAG_BITS-1:0]          mag_t;

    typedef struct packed {
        coord_t [2:0] va;
        edge_t  [2:0] ab;
        edge_t  [2:0] ac;
        nrm_t   [2:0] nrm;
    } geom_t;

    typedef struct packed {
        logic                   ok;
        mag_t                   det;
        mag_t                   rem_t;
        mag_t                   rem_v;
        mag_t                   rem_w;
        logic [DIST_BITS-1:0]   feed_t;
        logic [WEIGHT_BITS-1:0] feed_v;
        logic [WEIGHT_BITS-1:0] feed_w;
        logic [DIST_BITS-1:0]   quo_t;
        logic [WEIGHT_BITS-1:0] quo_v;
        logic [WEIGHT_BITS-1:0] quo_w;
    } div_req_t;

    typedef struct packed {
        logic                   ok;
        logic                   rem_nz;
        logic [DIST_BITS-1:0]   quo_t;
        logic [WEIGHT_BITS-1:0] quo_v;
        logic [WEIGHT_BITS-1:0] quo_w;
    } div_res_t;

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [MAG_BITS:0] div_step(input mag_t rem, input mag_t det,
                                                    input logic feed);
        logic [MAG_BITS:0]   shifted;
        logic [MAG_BITS+1:0] diff;
        begin
            shifted = {rem, feed};
            diff    = {1'b0, shifted} - {2'b00, det};
            if (diff[MAG_BITS+1])
                return {1'b0, shifted[MAG_BITS-1:0]};
            else
                return {1'b1, diff[MAG_BITS-1:0]};
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/ray_triangle_intersect.sv =====
// Top level of the ray / triangle intersection pipeline
//
// Load the triangle through write_en / reg_index / write_data: index 0..2 are
// vertices A, B, C (three packed signed Q10.10 coordinates, x lowest), index 3
// is the minimum distance in Q16.16. Writes take effect at once; the derived
// edges and plane normal settle through their registers in time for a request
// issued on the next cycle. Write only while no request is in flight.
// Issue a ray by raising start with origin and direction; busy stays low, so a
// request is taken on every cycle that start is high.
// Each request gives one result: done is high for one cycle, with hit,
// distance (Q16.16) and the barycentric weights bary_u, bary_v, bary_w
// (Q1.16). A miss returns hit low, distance all ones and zero weights.
// The pipeline is 7 stages of products and checks, 32 divider stages (one quotient
// bit each) and one output register; throughput is one ray per cycle.
// The receiver cannot stall: the result is on the ports for exactly one cycle.
// Reset clears the pipeline valids and restores the register reset values.
`default_nettype none
`include "assert_macros.svh"

module ray_triangle_intersect (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  rti_pkg::coord_t                     origin_x,
    input  rti_pkg::coord_t                     origin_y,
    input  rti_pkg::coord_t                     origin_z,
    input  rti_pkg::coord_t                     dir_x,
    input  rti_pkg::coord_t                     dir_y,
    input  rti_pkg::coord_t                     dir_z,
    output logic                                done,
    output logic                                hit,
    output logic [rti_pkg::DIST_BITS-1:0]       distance,
    output logic [rti_pkg::WEIGHT_BITS-1:0]     bary_u,
    output logic [rti_pkg::WEIGHT_BITS-1:0]     bary_v,
    output logic [rti_pkg::WEIGHT_BITS-1:0]     bary_w,
    input  logic                                write_en,
    input  logic [rti_pkg::INDEX_BITS-1:0]      reg_index,
    input  logic [rti_pkg::VERTEX_BITS-1:0]     write_data
);
    import rti_pkg::*;

    geom_t                  geom;
    logic [MIN_BITS-1:0]    min_distance;
    logic                   front_valid;
    div_req_t               front_req;
    logic                   div_valid;
    div_res_t               div_res;
    logic                   beyond_min;
    logic                   hit_next;
    logic                   done_reg;
    logic                   hit_reg;
    logic [DIST_BITS-1:0]   dist_reg;
    logic [DIST_BITS-1:0]   dist_next;
    logic [WEIGHT_BITS-1:0] u_reg;
    logic [WEIGHT_BITS-1:0] u_next;
    logic [WEIGHT_BITS-1:0] v_reg;
    logic [WEIGHT_BITS-1:0] v_next;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic [WEIGHT_BITS-1:0] w_next;

    assign busy = 1'b0;

    rti_config u_config (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_en     (write_en),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .geom         (geom),
        .min_distance (min_distance)
    );

    rti_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .origin_x  (origin_x),
        .origin_y  (origin_y),
        .origin_z  (origin_z),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .dir_z     (dir_z),
        .geom      (geom),
        .out_valid (front_valid),
        .out_req   (front_req)
    );

    rti_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_req    (front_req),
        .out_valid (div_valid),
        .out_res   (div_res)
    );

    // exact compare: t > min holds if the quotient is above, or equal with a remainder
    always_comb
    begin
        beyond_min = (div_res.quo_t > min_distance)
                     || ((div_res.quo_t == min_distance) && div_res.rem_nz);
        hit_next   = div_res.ok && beyond_min;
        if (hit_next)
        begin
            dist_next = div_res.quo_t;
            v_next    = div_res.quo_v;
            w_next    = div_res.quo_w;
            u_next    = WEIGHT_ONE - div_res.quo_v - div_res.quo_w;
        end
        else
        begin
            dist_next = DIST_MISS;
            v_next    = '0;
            w_next    = '0;
            u_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= hit_next;
        dist_reg <= dist_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        w_reg    <= w_next;
    end

    assign done     = done_reg;
    assign hit      = hit_reg;
    assign distance = dist_reg;
    assign bary_u   = u_reg;
    assign bary_v   = v_reg;
    assign bary_w   = w_reg;

    `RTI_ASSERT_IMPL(a_done_has_request, done, $past(start && !busy, LATENCY), "result without a request")
    `RTI_ASSERT_IMPL(a_miss_fields, done && !hit, (distance == DIST_MISS) && (bary_u == '0) && (bary_v == '0) && (bary_w == '0), "miss result fields wrong")
    `RTI_ASSERT_IMPL(a_weight_sum, done && hit, ((WEIGHT_BITS+1)'(bary_u) + (WEIGHT_BITS+1)'(bary_v) + (WEIGHT_BITS+1)'(bary_w)) == (WEIGHT_BITS+1)'(WEIGHT_ONE), "weights do not sum to one")
    `RTI_ASSERT_NEVER(a_hit_too_close, done && hit && (distance < min_distance), "hit below minimum distance")

endmodule

`default_nettype wire

// ===== sv/rti_config.sv =====
// Configuration registers and the derived triangle edges and plane normal
`default_nettype none

module rti_config (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              write_en,
    input  logic [rti_pkg::INDEX_BITS-1:0]    reg_index,
    input  logic [rti_pkg::VERTEX_BITS-1:0]   write_data,
    output rti_pkg::geom_t                    geom,
    output logic [rti_pkg::MIN_BITS-1:0]      min_distance
);
    import rti_pkg::*;

    logic [VERTEX_BITS-1:0] va_reg;
    logic [VERTEX_BITS-1:0] vb_reg;
    logic [VERTEX_BITS-1:0] vc_reg;
    logic [MIN_BITS-1:0]    min_reg;
    coord_t                 a_c [3];
    coord_t                 b_c [3];
    coord_t                 c_c [3];
    edge_t                  ab_reg [3];
    edge_t                  ac_reg [3];
    nrm_t                   na_reg [3];
    nrm_t                   nb_reg [3];
    nrm_t                   nrm_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg  <= '0;
            vb_reg  <= '0;
            vc_reg  <= '0;
            min_reg <= MIN_DIST_RESET;
        end
        else if (write_en)
        begin
            case (reg_index)
                REG_VERTEX_A: va_reg  <= write_data;
                REG_VERTEX_B: vb_reg  <= write_data;
                REG_VERTEX_C: vc_reg  <= write_data;
                REG_MIN_DIST: min_reg <= write_data[MIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            a_c[k] = coord_t'(va_reg[k*COORD_BITS +: COORD_BITS]);
            b_c[k] = coord_t'(vb_reg[k*COORD_BITS +: COORD_BITS]);
            c_c[k] = coord_t'(vc_reg[k*COORD_BITS +: COORD_BITS]);
        end
    end

    // edges, then cross products, then normal
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ab_reg[k]  <= '0;
                ac_reg[k]  <= '0;
                na_reg[k]  <= '0;
                nb_reg[k]  <= '0;
                nrm_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                ab_reg[k]  <= EDGE_BITS'(b_c[k]) - EDGE_BITS'(a_c[k]);
                ac_reg[k]  <= EDGE_BITS'(c_c[k]) - EDGE_BITS'(a_c[k]);
                na_reg[k]  <= NRM_BITS'(ab_reg[NEXT1[k]]) * NRM_BITS'(ac_reg[NEXT2[k]]);
                nb_reg[k]  <= NRM_BITS'(ab_reg[NEXT2[k]]) * NRM_BITS'(ac_reg[NEXT1[k]]);
                nrm_reg[k] <= na_reg[k] - nb_reg[k];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            geom.va[k]  = a_c[k];
            geom.ab[k]  = ab_reg[k];
            geom.ac[k]  = ac_reg[k];
            geom.nrm[k] = nrm_reg[k];
        end
    end

    assign min_distance = min_reg;

endmodule

`default_nettype wire

// ===== sv/rti_front.sv =====
// Front pipeline: cross and dot products, sign fix-up, hit checks, divider setup
`default_nettype none

module rti_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  rti_pkg::coord_t     origin_x,
    input  rti_pkg::coord_t     origin_y,
    input  rti_pkg::coord_t     origin_z,
    input  rti_pkg::coord_t     dir_x,
    input  rti_pkg::coord_t     dir_y,
    input  rti_pkg::coord_t     dir_z,
    input  rti_pkg::geom_t      geom,
    output logic                out_valid,
    output rti_pkg::div_req_t   out_req
);
    import rti_pkg::*;

    logic [FRONT_STAGES-1:0] vld_reg;
    coord_t   o_in [3];
    coord_t   d_in [3];
    edge_t    t1_reg [3];
    coord_t   d1_reg [3];
    edge_t    t2_reg [3];
    coord_t   d2_reg [3];
    pv_t      pa2_reg [3];
    pv_t      pb2_reg [3];
    nrm_t     qa2_reg [3];
    nrm_t     qb2_reg [3];
    edge_t    t3_reg [3];
    coord_t   d3_reg [3];
    pv_t      pv3_reg [3];
    nrm_t     qv3_reg [3];
    prod_t    det4_reg [3];
    prod_t    tn4_reg [3];
    prod_t    vn4_reg [3];
    prod_t    wn4_reg [3];
    sum_t     det5_reg;
    sum_t     tn5_reg;
    sum_t     vn5_reg;
    sum_t     wn5_reg;
    logic     zero6_reg;
    sum_t     det6_reg;
    sum_t     tn6_reg;
    sum_t     vn6_reg;
    sum_t     wn6_reg;
    div_req_t req_next;
    div_req_t req_reg;

    assign o_in[0] = origin_x;
    assign o_in[1] = origin_y;
    assign o_in[2] = origin_z;
    assign d_in[0] = dir_x;
    assign d_in[1] = dir_y;
    assign d_in[2] = dir_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            t1_reg[k]  <= EDGE_BITS'(o_in[k]) - EDGE_BITS'(geom.va[k]);
            d1_reg[k]  <= d_in[k];

            t2_reg[k]  <= t1_reg[k];
            d2_reg[k]  <= d1_reg[k];
            pa2_reg[k] <= PV_BITS'(d1_reg[NEXT1[k]]) * PV_BITS'(geom.ac[NEXT2[k]]);
            pb2_reg[k] <= PV_BITS'(d1_reg[NEXT2[k]]) * PV_BITS'(geom.ac[NEXT1[k]]);
            qa2_reg[k] <= NRM_BITS'(t1_reg[NEXT1[k]]) * NRM_BITS'(geom.ab[NEXT2[k]]);
            qb2_reg[k] <= NRM_BITS'(t1_reg[NEXT2[k]]) * NRM_BITS'(geom.ab[NEXT1[k]]);

            t3_reg[k]  <= t2_reg[k];
            d3_reg[k]  <= d2_reg[k];
            pv3_reg[k] <= pa2_reg[k] - pb2_reg[k];
            qv3_reg[k] <= qa2_reg[k] - qb2_reg[k];

            det4_reg[k] <= PROD_BITS'(geom.ab[k]) * PROD_BITS'(pv3_reg[k]);
            tn4_reg[k]  <= PROD_BITS'(geom.nrm[k]) * PROD_BITS'(t3_reg[k]);
            vn4_reg[k]  <= PROD_BITS'(t3_reg[k]) * PROD_BITS'(pv3_reg[k]);
            wn4_reg[k]  <= PROD_BITS'(d3_reg[k]) * PROD_BITS'(qv3_reg[k]);
        end

        det5_reg <= SUM_BITS'(det4_reg[0]) + SUM_BITS'(det4_reg[1]) + SUM_BITS'(det4_reg[2]);
        tn5_reg  <= SUM_BITS'(tn4_reg[0]) + SUM_BITS'(tn4_reg[1]) + SUM_BITS'(tn4_reg[2]);
        vn5_reg  <= SUM_BITS'(vn4_reg[0]) + SUM_BITS'(vn4_reg[1]) + SUM_BITS'(vn4_reg[2]);
        wn5_reg  <= SUM_BITS'(wn4_reg[0]) + SUM_BITS'(wn4_reg[1]) + SUM_BITS'(wn4_reg[2]);

        // flip all terms if the denominator is negative, so it is never negative
        zero6_reg <= (det5_reg == '0);
        if (det5_reg[SUM_BITS-1])
        begin
            det6_reg <= -det5_reg;
            tn6_reg  <= -tn5_reg;
            vn6_reg  <= -vn5_reg;
            wn6_reg  <= -wn5_reg;
        end
        else
        begin
            det6_reg <= det5_reg;
            tn6_reg  <= tn5_reg;
            vn6_reg  <= vn5_reg;
            wn6_reg  <= wn5_reg;
        end

        req_reg <= req_next;
    end

    always_comb
    begin
        logic signed [SUM_BITS+1:0] slack;
        logic                       tn_pos;
        logic                       fits;
        slack  = (SUM_BITS+2)'(det6_reg) - (SUM_BITS+2)'(vn6_reg) - (SUM_BITS+2)'(wn6_reg);
        tn_pos = !tn6_reg[SUM_BITS-1] && (tn6_reg != '0);
        fits   = {{(DIST_BITS-DIST_FRAC){1'b0}}, tn6_reg[MAG_BITS-1:0]}
                 < {det6_reg[MAG_BITS-1:0], {(DIST_BITS-DIST_FRAC){1'b0}}};

        req_next.ok     = !zero6_reg && tn_pos && !vn6_reg[SUM_BITS-1]
                          && !wn6_reg[SUM_BITS-1] && !slack[SUM_BITS+1] && fits;
        req_next.det    = det6_reg[MAG_BITS-1:0];
        req_next.rem_t  = MAG_BITS'(tn6_reg[MAG_BITS-1:DIST_BITS-DIST_FRAC]);
        req_next.feed_t = {tn6_reg[DIST_BITS-DIST_FRAC-1:0], {DIST_FRAC{1'b0}}};
        req_next.rem_v  = MAG_BITS'(vn6_reg[MAG_BITS-1:1]);
        req_next.feed_v = {vn6_reg[0], {DIST_FRAC{1'b0}}};
        req_next.rem_w  = MAG_BITS'(wn6_reg[MAG_BITS-1:1]);
        req_next.feed_w = {wn6_reg[0], {DIST_FRAC{1'b0}}};
        req_next.quo_t  = '0;
        req_next.quo_v  = '0;
        req_next.quo_w  = '0;
    end

    assign out_valid = vld_reg[FRONT_STAGES-1];
    assign out_req   = req_reg;

endmodule

`default_nettype wire

// ===== sv/rti_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage for distance and weights
`default_nettype none

module rti_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  rti_pkg::div_req_t   in_req,
    output logic                out_valid,
    output rti_pkg::div_res_t   out_res
);
    import rti_pkg::*;

    logic [DIST_BITS-1:0] vld_reg;
    div_req_t             stage_reg [DIST_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[DIST_BITS-2:0], in_valid};
    end

    for (genvar i = 0; i < DIST_BITS; i++)
    begin : g_stage
        div_req_t          cur;
        div_req_t          stage_next;
        logic [MAG_BITS:0] step_t;

        if (i == 0)
        begin : g_first
            assign cur = in_req;
        end
        else
        begin : g_rest
            assign cur = stage_reg[i-1];
        end

        assign step_t = div_step(cur.rem_t, cur.det, cur.feed_t[DIST_BITS-1]);

        if (i < WEIGHT_BITS)
        begin : g_weight
            logic [MAG_BITS:0] step_v;
            logic [MAG_BITS:0] step_w;

            assign step_v = div_step(cur.rem_v, cur.det, cur.feed_v[WEIGHT_BITS-1]);
            assign step_w = div_step(cur.rem_w, cur.det, cur.feed_w[WEIGHT_BITS-1]);

            always_comb
            begin
                stage_next        = cur;
                stage_next.rem_t  = step_t[MAG_BITS-1:0];
                stage_next.quo_t  = {cur.quo_t[DIST_BITS-2:0], step_t[MAG_BITS]};
                stage_next.feed_t = cur.feed_t << 1;
                stage_next.rem_v  = step_v[MAG_BITS-1:0];
                stage_next.quo_v  = {cur.quo_v[WEIGHT_BITS-2:0], step_v[MAG_BITS]};
                stage_next.feed_v = cur.feed_v << 1;
                stage_next.rem_w  = step_w[MAG_BITS-1:0];
                stage_next.quo_w  = {cur.quo_w[WEIGHT_BITS-2:0], step_w[MAG_BITS]};
                stage_next.feed_w = cur.feed_w << 1;
            end
        end
        else
        begin : g_dist
            always_comb
            begin
                stage_next        = cur;
                stage_next.rem_t  = step_t[MAG_BITS-1:0];
                stage_next.quo_t  = {cur.quo_t[DIST_BITS-2:0], step_t[MAG_BITS]};
                stage_next.feed_t = cur.feed_t << 1;
            end
        end

        always_ff @(posedge clk)
        begin
            stage_reg[i] <= stage_next;
        end
    end

    assign out_valid      = vld_reg[DIST_BITS-1];
    assign out_res.ok     = stage_reg[DIST_BITS-1].ok;
    assign out_res.rem_nz = |stage_reg[DIST_BITS-1].rem_t;
    assign out_res.quo_t  = stage_reg[DIST_BITS-1].quo_t;
    assign out_res.quo_v  = stage_reg[DIST_BITS-1].quo_v;
    assign out_res.quo_w  = stage_reg[DIST_BITS-1].quo_w;

endmodule

`default_nettype wire
